FILE: rtl/core/fss_pkg.sv
`default_nettype none

package fss_pkg;

    // Request kinds, same codes as the func field on the input stream.
    typedef enum logic [1:0] {
        OP_PATTERN = 2'd0,
        OP_TEXT    = 2'd1,
        OP_FINISH  = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_req;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    typedef struct packed {
        logic pop;   // head request taken by the engine
        logic load;  // result loaded into the output register
    } t_bstat;

    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = $clog2(QDEPTH);
    localparam int QCNT_BITS  = $clog2(QDEPTH + 1);
    localparam int IN_BITS    = 8;
    localparam int USER_BITS  = 2;
    localparam int OUT_BITS   = 24;
    localparam int INDEX_BITS = 16;

endpackage

`default_nettype wire

FILE: rtl/core/fss_front.sv
`default_nettype none

module fss_front
    import fss_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [USER_BITS-1:0] i_func,
    input  wire logic [IN_BITS-1:0]   i_byte,
    input  wire logic                 i_pop,
    output t_req                      o_head,
    output t_qstat                    o_qstat
);

    t_req                 r_q [QDEPTH];
    logic [QPTR_BITS-1:0] r_wr, n_wr;
    logic [QPTR_BITS-1:0] r_rd, n_rd;
    logic [QCNT_BITS-1:0] r_count, n_count;
    logic                 keep;
    logic                 push;

    // Classify: unused func code is accepted and dropped.
    always_comb begin
        unique case (i_func)
            OP_PATTERN, OP_TEXT, OP_FINISH: keep = 1'b1;
            default:                        keep = 1'b0;
        endcase
    end

    assign o_ready = (r_count != QCNT_BITS'(QDEPTH));
    assign push    = i_valid && o_ready && keep;

    always_comb begin
        n_wr    = push  ? r_wr + 1'b1 : r_wr;
        n_rd    = i_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count + QCNT_BITS'(push) - QCNT_BITS'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= '{op: t_op'(i_func), data: i_byte};
        end
    end

    assign o_head        = r_q[r_rd];
    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.full  = !o_ready;

endmodule

`default_nettype wire

FILE: rtl/core/fss_back.sv
`default_nettype none

module fss_back
    import fss_pkg::*;
#(
    parameter int PATTERN_MAX   = 16,
    parameter int POSITION_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_req                i_head,
    input  wire t_qstat              i_qstat,
    output t_bstat                   o_bstat,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [OUT_BITS-1:0]      o_data
);

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int CW = POSITION_BITS + LW;

    // Pattern held newest-first so cell k always faces window cell k.
    logic [7:0]               r_pat [PATTERN_MAX];
    logic [7:0]               r_win [PATTERN_MAX];
    logic [7:0]               win_new [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]   hit;
    logic [LW-1:0]            r_len;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_first;
    logic                     r_seen;
    logic                     r_ovf;
    logic                     r_out_valid;
    logic [OUT_BITS-1:0]      r_out_data;
    logic                     slot_free;
    logic                     pop;
    logic                     load;
    logic                     window_ok;
    logic [CW-1:0]            diff;
    logic [POSITION_BITS-1:0] sel_idx;
    logic [POSITION_BITS+INDEX_BITS-1:0] idx_ext;

    assign slot_free = !r_out_valid || i_ready;
    assign pop       = !i_qstat.empty && ((i_head.op != OP_FINISH) || slot_free);
    assign load      = pop && (i_head.op == OP_FINISH);

    assign n_pos = r_pos + POSITION_BITS'(r_pos != '1);

    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            win_new[k] = (k == 0) ? i_head.data : r_win[(k == 0) ? 0 : k - 1];
            hit[k]     = (k >= int'(r_len)) || (r_pat[k] == win_new[k]);
        end
    end

    assign window_ok = (&hit) && (r_len != '0) && (CW'(n_pos) >= CW'(r_len));
    assign diff      = CW'(n_pos) - CW'(r_len);
    assign sel_idx   = r_seen ? r_first : '0;
    assign idx_ext   = {{INDEX_BITS{1'b0}}, sel_idx};

    // Shift stores, no reset: only cells below r_len are ever compared.
    always_ff @(posedge i_clk) begin
        if (pop && (i_head.op == OP_TEXT)) begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
                r_win[k] <= win_new[k];
            end
        end
        if (pop && (i_head.op == OP_PATTERN) && (r_len != LW'(PATTERN_MAX))) begin
            r_pat[0] <= i_head.data;
            for (int k = 1; k < PATTERN_MAX; k++) begin
                r_pat[k] <= r_pat[k-1];
            end
        end
        if (load) begin
            r_out_data <= {{(OUT_BITS-INDEX_BITS-2){1'b0}}, r_ovf,
                           idx_ext[INDEX_BITS-1:0], (r_len == '0) || r_seen};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_pos       <= '0;
            r_first     <= '0;
            r_seen      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (pop) begin
                case (i_head.op)
                    OP_PATTERN: begin
                        if (r_len != LW'(PATTERN_MAX)) begin
                            r_len <= r_len + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    OP_TEXT: begin
                        r_pos <= n_pos;
                        if (!r_seen && window_ok) begin
                            r_seen  <= 1'b1;
                            r_first <= diff[POSITION_BITS-1:0];
                        end
                    end
                    OP_FINISH: begin
                        r_len   <= '0;
                        r_pos   <= '0;
                        r_first <= '0;
                        r_seen  <= 1'b0;
                        r_ovf   <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_bstat.pop  = pop;
    assign o_bstat.load = load;
    assign o_valid      = r_out_valid;
    assign o_data       = r_out_data;

endmodule

`default_nettype wire

FILE: rtl/core/first_substring_match.sv
// first_substring_match: streaming first-occurrence substring search.
// Slave stream carries requests: tuser is the kind (0 pattern byte, 1 text
// byte, 2 finish), tdata the byte. Kind 3 is accepted and dropped.
// Load pattern bytes first, then stream text; a finish request returns one
// result on the master stream and clears the search for the next run.
// Each text byte is compared against the whole pattern at once by a
// row of byte comparators, so requests are taken one per cycle unless a
// finish waits on a stalled master side. Throughput: 1 request per cycle
// outside such stalls, set by the 4-entry request queue and the comparator row.
// Result path: an accepted finish is written into the request queue and,
// once requests queued ahead of it are taken and the output slot is free,
// loads the output register that drives the master stream.
// When the master side stalls, the result waits in the output register;
// pattern and text requests behind it keep flowing, a second finish waits
// in the queue, and tready drops only when the queue is full.
// Reset (synchronous, active low) empties the queue and the output register
// and clears pattern length, position and flags. No clearing pass is needed.
// Position counts saturate at 2^POSITION_BITS-1.
`default_nettype none

module first_substring_match
    import fss_pkg::*;
#(
    parameter int PATTERN_MAX   = 16,
    parameter int POSITION_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [IN_BITS-1:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic [USER_BITS-1:0] i_s_axis_tuser,   // [1:0] func
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [OUT_BITS-1:0]       o_m_axis_tdata    // [0] found, [16:1] match_index,
                                                        // [17] pattern_overflow, rest 0
);

    t_req   head;
    t_qstat qstat;
    t_bstat bstat;

    // Front: accept and classify requests, queue them.
    fss_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_func  (i_s_axis_tuser),
        .i_byte  (i_s_axis_tdata),
        .i_pop   (bstat.pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    // Back: pattern/window shift registers, comparators, result register.
    fss_back #(
        .PATTERN_MAX   (PATTERN_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_bstat (bstat),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

    // Engine never takes from an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bstat.pop |-> !qstat.empty)
        else $error("pop from empty request queue");

    // A kept request lands in the queue.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready &&
         (i_s_axis_tuser == OP_PATTERN || i_s_axis_tuser == OP_TEXT ||
          i_s_axis_tuser == OP_FINISH)) |=> !qstat.empty)
        else $error("accepted request lost");

    // A result is loaded only when the output slot is free.
    a_load_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bstat.load |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result overwrote a pending result");

    // tready low means the queue is really full.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> qstat.full && !qstat.empty)
        else $error("tready low with room in queue");

endmodule

`default_nettype wire

FILE: bench/tb.sv
`default_nettype none

module tb;
    import fss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PAT_MAX       = 16;
    localparam int          DRAIN_CYCLES  = 4;
    localparam int          NO_IDLE_ITEMS = 200;
    localparam int          RANDOM_ITEMS  = 1650;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;  // accepted and dropped by the block

    typedef struct packed {
        logic        found;
        logic [15:0] match_index;
        logic        overflow;
    } t_report;

    logic                 i_clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic [IN_BITS-1:0]   s_tdata;    // [7:0] data_byte
    logic [USER_BITS-1:0] s_tuser;    // [1:0] func
    logic                 m_tready;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [OUT_BITS-1:0]  o_m_axis_tdata;  // [0] found, [16:1] match_index,
                                           // [17] pattern_overflow

    // Search state mirrored from the block's behavior.
    logic [7:0]  pat_store [PAT_MAX];
    logic [4:0]  pat_len;
    logic [7:0]  text_win [PAT_MAX];      // entry 0 holds the newest text byte
    logic [15:0] text_pos;
    logic        hit_seen;
    logic [15:0] hit_pos;
    logic        ovf_seen;

    t_report pending_reports [$];
    int      items_sent;
    int      error_count;
    bit      no_idle;

    first_substring_match u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("tb: failure");
        $finish;
    end

    function automatic void clear_search();
        for (int k = 0; k < PAT_MAX; k++) begin
            pat_store[k] = 8'h00;
            text_win[k]  = 8'h00;
        end
        pat_len  = '0;
        text_pos = '0;
        hit_seen = 1'b0;
        hit_pos  = '0;
        ovf_seen = 1'b0;
    endfunction

    // Full window compare against the stored pattern; newest byte pairs with
    // the last pattern byte.
    function automatic bit window_hit();
        bit ok;
        ok = (pat_len != 0);
        for (int j = 0; j < PAT_MAX; j++) begin
            if (j < pat_len && pat_store[j] != text_win[pat_len - 1 - j])
                ok = 0;
        end
        return ok;
    endfunction

    // Advance the mirrored search by one accepted request; a finish queues
    // its report and clears the search.
    function automatic void predict_search(input logic [1:0] func, input logic [7:0] data);
        t_report rep;
        case (func)
            OP_PATTERN: begin
                if (pat_len < PAT_MAX) begin
                    pat_store[pat_len] = data;
                    pat_len = pat_len + 1'b1;
                end else begin
                    ovf_seen = 1'b1;
                end
            end
            OP_TEXT: begin
                for (int k = PAT_MAX - 1; k > 0; k--)
                    text_win[k] = text_win[k - 1];
                text_win[0] = data;
                if (text_pos != 16'hFFFF)
                    text_pos = text_pos + 1'b1;
                if (!hit_seen && pat_len != 0 && text_pos >= pat_len && window_hit()) begin
                    hit_seen = 1'b1;
                    hit_pos  = text_pos - pat_len;
                end
            end
            OP_FINISH: begin
                rep.found       = (pat_len == 0) || hit_seen;
                rep.match_index = (pat_len != 0 && hit_seen) ? hit_pos : 16'd0;
                rep.overflow    = ovf_seen;
                pending_reports.push_back(rep);
                clear_search();
            end
            default: ;
        endcase
    endfunction

    // One request on the slave stream, with an optional random gap first.
    // tvalid stays high on return; a random gap before the next request, a
    // drain or the end of the run lowers it.
    task automatic send_req(input logic [1:0] func, input logic [7:0] data);
        if (!no_idle) begin
            while ($urandom_range(99) < 10) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= data;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_search(func, data);
        if (func != OP_UNUSED)
            items_sent++;
    endtask

    // Sender holds off until every queued report is out.
    task automatic wait_reports_drained();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte(input bit narrow, input logic [7:0] a,
                                             input logic [7:0] b);
        if (narrow)
            return $urandom_range(1) ? a : b;
        return 8'($urandom_range(255));
    endfunction

    // Receiver side: random stalls unless a no-idle stretch is running.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 10);
        end
    end

    // Report checker: every accepted result against the oldest expectation.
    always @(posedge i_clk) begin : report_check
        t_report got;
        t_report want;
        if (rst_n && o_m_axis_tvalid && m_tready) begin
            got.found       = o_m_axis_tdata[0];
            got.match_index = o_m_axis_tdata[16:1];
            got.overflow    = o_m_axis_tdata[17];
            if (pending_reports.size() == 0) begin
                error_count++;
                $display("%0t: unexpected report found=%0d index=%0d overflow=%0d",
                         $realtime, got.found, got.match_index, got.overflow);
            end else begin
                want = pending_reports.pop_front();
                if (got !== want) begin
                    error_count++;
                    $display("%0t: report mismatch expected found=%0d index=%0d overflow=%0d",
                             $realtime, want.found, want.match_index, want.overflow);
                    $display("%0t:                   actual found=%0d index=%0d overflow=%0d",
                             $realtime, got.found, got.match_index, got.overflow);
                end
            end
        end
    end

    // Empty pattern matches at 0, with or without text.
    task automatic test_empty_pattern();
        send_req(OP_FINISH, 8'h00);
        send_req(OP_TEXT, 8'h00);
        send_req(OP_TEXT, 8'hFF);
        send_req(OP_FINISH, 8'hFF);
    endtask

    // Pattern loaded, no text at all: not found.
    task automatic test_empty_text();
        send_req(OP_PATTERN, 8'hFF);
        send_req(OP_FINISH, 8'h5A);
    endtask

    // Text shorter than the pattern can never match.
    task automatic test_short_text();
        send_req(OP_PATTERN, 8'h00);
        send_req(OP_PATTERN, 8'hFF);
        send_req(OP_TEXT, 8'h00);
        send_req(OP_FINISH, 8'h00);
    endtask

    // Kind 3 in the middle of a search leaves it untouched.
    task automatic test_unused_code();
        send_req(OP_PATTERN, 8'hAB);
        send_req(OP_TEXT, 8'h55);
        send_req(OP_UNUSED, 8'hAB);
        send_req(OP_TEXT, 8'hAB);
        send_req(OP_FINISH, 8'h00);
    endtask

    // Pattern bytes arriving after text extend the pattern for later bytes.
    task automatic test_late_pattern();
        send_req(OP_TEXT, 8'h5A);
        send_req(OP_PATTERN, 8'h5A);
        send_req(OP_TEXT, 8'h5A);
        send_req(OP_TEXT, 8'hC3);
        send_req(OP_PATTERN, 8'hC3);
        send_req(OP_TEXT, 8'hC3);
        send_req(OP_FINISH, 8'h00);
    endtask

    // One search with random content; mostly well formed, with stray kind 3
    // requests, late pattern bytes and the odd missing finish.
    task automatic run_random_search(input bit force_long);
        logic [7:0] pat [$];
        logic [7:0] sym_a;
        logic [7:0] sym_b;
        bit         narrow;
        int         plen;
        int         tlen;
        int         plant_at;
        int         r;
        sym_a  = 8'($urandom_range(255));
        sym_b  = 8'($urandom_range(255));
        narrow = ($urandom_range(99) < 75);
        r      = $urandom_range(99);
        if (force_long || r < 5)
            plen = $urandom_range(20, 17);
        else if (r < 10)
            plen = 0;
        else if (r < 15)
            plen = PAT_MAX;
        else
            plen = $urandom_range(4, 1);
        for (int i = 0; i < plen; i++) begin
            pat.push_back(pick_byte(narrow, sym_a, sym_b));
            send_req(OP_PATTERN, pat[i]);
        end
        tlen     = (plen >= PAT_MAX) ? $urandom_range(40, 16) : $urandom_range(24);
        plant_at = ($urandom_range(99) < 35) ? $urandom_range(tlen) : -1;
        for (int i = 0; i <= tlen; i++) begin
            if (i == plant_at) begin
                foreach (pat[k])
                    if (k < PAT_MAX) send_req(OP_TEXT, pat[k]);
            end
            if (i == tlen)
                break;
            r = $urandom_range(99);
            if (r < 3)
                send_req(OP_UNUSED, 8'($urandom_range(255)));
            else if (r < 5)
                send_req(OP_PATTERN, pick_byte(narrow, sym_a, sym_b));
            send_req(OP_TEXT, pick_byte(narrow, sym_a, sym_b));
        end
        if ($urandom_range(99) >= 4)
            send_req(OP_FINISH, 8'($urandom_range(255)));
    endtask

    // Back-to-back stretch: no idling on either side for a run of searches.
    task automatic test_no_idle_stretch();
        int start;
        start   = items_sent;
        no_idle = 1'b1;
        while (items_sent - start < NO_IDLE_ITEMS)
            run_random_search(1'b0);
        send_req(OP_FINISH, 8'h00);
        no_idle = 1'b0;
    endtask

    task automatic test_random_searches();
        int start;
        start = items_sent;
        run_random_search(1'b1);
        while (items_sent - start < RANDOM_ITEMS)
            run_random_search(1'b0);
        send_req(OP_FINISH, 8'($urandom_range(255)));
    endtask

    initial begin
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        rst_n       <= 1'b0;
        items_sent  = 0;
        error_count = 0;
        no_idle     = 1'b0;
        clear_search();
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_pattern();
        test_empty_text();
        test_short_text();
        test_unused_code();
        test_late_pattern();
        wait_reports_drained();
        test_no_idle_stretch();
        wait_reports_drained();
        test_random_searches();

        s_tvalid <= 1'b0;
        for (int n = 0; n < 2000 && pending_reports.size() != 0; n++)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_reports.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: first_substring_match.f
rtl/core/fss_pkg.sv
rtl/core/fss_front.sv
rtl/core/fss_back.sv
rtl/core/first_substring_match.sv
bench/tb.sv
